// ===== rtl/stepper_phase_driver_with_ramp_unit_defines.svh =====
// Assertion macros shared by the stepper phase driver modules
`ifndef STEPPER_PHASE_DRIVER_WITH_RAMP_UNIT_DEFINES_SVH
`define STEPPER_PHASE_DRIVER_WITH_RAMP_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define SPDR_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("spdr: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define SPDR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("spdr: next-cycle check failed");

`endif

// ===== rtl/spdr_pkg.sv =====
// Types and constants shared by the stepper phase driver modules
`default_nettype none

package spdr_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_PERIOD,
    S_MOD,
    S_REM,
    S_DONE
  } state_t;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Ramp mode codes; the unused code holds
  localparam logic [1:0] RAMP_HOLD = 2'd0;
  localparam logic [1:0] RAMP_UP   = 2'd1;
  localparam logic [1:0] RAMP_DOWN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_RAMP_A = 2'd0;
  localparam logic [1:0] REG_RAMP_B = 2'd1;
  localparam logic [1:0] REG_RAMP_C = 2'd2;
  localparam logic [1:0] RAMP_REGS  = 2'd3;

  localparam logic [7:0] PATTERN_RESET = 8'h88;
  localparam logic [7:0] SPEED_MAX     = 8'd255;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic clear_hit;
    logic div_start;
    logic mod_start;
    logic div_step;
    logic eval_period;
    logic eval_rem;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic period_skip;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/stepper_phase_driver_with_ramp_unit.sv =====
// Top level of the three-motor stepper phase driver with speed ramp
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | in_valid / in_stall  | operation, motor_select, turn_right,
//            |                      | new_speed
//   output   | out_valid / out_stall| drive_phase, stepped, speed_now
//   config   | cfg_write            | cfg_index, cfg_data
//
// One item at a time. A load, a tick at speed zero or an unknown motor goes
// from the check state straight to commit. A tick at nonzero speed runs the
// period divide over DIV_W quotient bits (DIV_W = max(clog2(RATE_SCALE+1), 9),
// so 11 by default), then the modulo pass when the period is nonzero and fits
// in 8 bits; both run on one shared restoring divider, one bit a cycle.
// Reset clears the pattern to 0x88, the counter, all speeds and ramp modes.
// A new word is accepted while the last result waits; a stalled result holds
// the block in its commit state until the word is taken.
`default_nettype none

module stepper_phase_driver_with_ramp_unit
  import spdr_pkg::*;
#(
  parameter int MOTOR_COUNT = 3,
  parameter int RATE_SCALE  = 1275
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       operation,
  input  wire logic [1:0] motor_select,
  input  wire logic       turn_right,
  input  wire logic [7:0] new_speed,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      drive_phase,
  output logic            stepped,
  output logic [7:0]      speed_now,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Sequence each word
  spdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold motor state and compute the result
  spdr_dp #(
    .MOTOR_COUNT (MOTOR_COUNT),
    .RATE_SCALE  (RATE_SCALE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .operation    (operation),
    .motor_select (motor_select),
    .turn_right   (turn_right),
    .new_speed    (new_speed),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .drive_phase  (drive_phase),
    .stepped      (stepped),
    .speed_now    (speed_now)
  );

endmodule

`default_nettype wire

// ===== rtl/spdr_ctrl.sv =====
// Sequencer for one item: speed divide, tick modulo, commit
`default_nettype none
`include "stepper_phase_driver_with_ramp_unit_defines.svh"

module spdr_ctrl
  import spdr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Advance the sequence and issue commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.clear_hit = 1'b1;
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_PERIOD;
        end
      end
      S_PERIOD: begin
        if (status.period_skip) begin
          cmd.eval_period = 1'b1;
          state_next      = S_DONE;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end
      end
      S_MOD: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_REM;
        end
      end
      S_REM: begin
        cmd.eval_rem = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Set valid on commit, drop it once the word is taken
  assign out_valid_next = cmd.commit | (out_valid & out_stall);

  `SPDR_ASSERT_NEXT(a_accept_to_check, state == S_IDLE && in_valid, state == S_CHECK)
  `SPDR_ASSERT_SAME(a_commit_needs_room, cmd.commit, !(out_valid && out_stall))
  `SPDR_ASSERT_NEXT(a_commit_shows_word, cmd.commit, out_valid && state == S_IDLE)

endmodule

`default_nettype wire

// ===== rtl/spdr_dp.sv =====
// Datapath: motor state, ramp registers, shared restoring divider, result word
`default_nettype none
`include "stepper_phase_driver_with_ramp_unit_defines.svh"

module spdr_dp
  import spdr_pkg::*;
#(
  parameter int MOTOR_COUNT = 3,
  parameter int RATE_SCALE  = 1275
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  output status_t         status,
  input  wire logic       operation,
  input  wire logic [1:0] motor_select,
  input  wire logic       turn_right,
  input  wire logic [7:0] new_speed,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data,
  output logic [3:0]      drive_phase,
  output logic            stepped,
  output logic [7:0]      speed_now
);

  localparam int SCALE_W = $clog2(RATE_SCALE + 1);
  localparam int DIV_W   = (SCALE_W > 9) ? SCALE_W : 9;
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam int IDX_W   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [3:0] MOTOR_LIMIT = 4'(MOTOR_COUNT);

  // Shared state
  logic [7:0] phase_pattern;
  logic [7:0] tick_count;
  logic [7:0] motor_speed [MOTOR_COUNT];
  logic [1:0] ramp_reg [3];

  // Latched item
  logic       item_op;
  logic [1:0] item_motor;
  logic       item_right;
  logic [7:0] item_speed;

  // Divider
  logic [DIV_W-1:0] div_quot;
  logic [7:0]       div_rem;
  logic [7:0]       div_divisor;
  logic [CNT_W-1:0] div_count;
  logic [8:0]       div_shifted;
  logic [8:0]       div_diff;
  logic             div_ge;

  logic             hit;
  logic             in_range;
  logic [IDX_W-1:0] motor_idx;
  logic [7:0]       speed_sel;
  logic [1:0]       mode_sel;
  logic [7:0]       speed_ramped;
  logic [7:0]       tick_next;
  logic [3:0]       nibble;
  logic [7:0]       pattern_rot;
  logic             is_tick;
  logic             period_big;
  logic             period_zero;

  assign in_range  = ({2'b00, item_motor} < MOTOR_LIMIT);
  assign motor_idx = IDX_W'(item_motor);
  assign speed_sel = in_range ? motor_speed[motor_idx] : 8'd0;
  assign mode_sel  = (in_range && item_motor < RAMP_REGS) ? ramp_reg[item_motor] : RAMP_HOLD;
  assign tick_next = tick_count + 8'd1;
  assign is_tick   = in_range && (item_op == OP_TICK);
  assign nibble    = (item_motor == 2'd0) ? phase_pattern[7:4] : phase_pattern[3:0];
  assign pattern_rot = item_right ? {phase_pattern[0], phase_pattern[7:1]}
                                  : {phase_pattern[6:0], phase_pattern[7]};

  assign period_big  = |div_quot[DIV_W-1:8];
  assign period_zero = (div_quot == '0);

  assign status.need_div    = is_tick && (speed_sel != 8'd0);
  assign status.div_last    = (div_count == CNT_W'(1));
  assign status.period_skip = period_big || period_zero;

  // Ramp the selected speed
  always_comb begin
    unique case (mode_sel)
      RAMP_UP: begin
        speed_ramped = (speed_sel != SPEED_MAX) ? speed_sel + 8'd1 : speed_sel;
      end
      RAMP_DOWN: begin
        if (speed_sel > 8'd2) begin
          speed_ramped = speed_sel - 8'd2;
        end else if (speed_sel != 8'd0) begin
          speed_ramped = speed_sel - 8'd1;
        end else begin
          speed_ramped = speed_sel;
        end
      end
      default: begin
        speed_ramped = speed_sel;
      end
    endcase
  end

  // Restoring step: trial subtract of the divisor
  assign div_shifted = {div_rem, div_quot[DIV_W-1]};
  assign div_ge      = (div_shifted >= {1'b0, div_divisor});
  assign div_diff    = div_shifted - {1'b0, div_divisor};

  // Write ramp registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ramp_reg[i] <= RAMP_HOLD;
      end
    end else if (cfg_write && cfg_index < RAMP_REGS && {2'b00, cfg_index} < MOTOR_LIMIT) begin
      ramp_reg[cfg_index] <= cfg_data;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_op    <= operation;
      item_motor <= motor_select;
      item_right <= turn_right;
      item_speed <= new_speed;
    end
  end

  // Run the divider: speed period first, then tick modulo period
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_quot    <= DIV_W'(RATE_SCALE);
      div_divisor <= speed_sel;
      div_rem     <= 8'd0;
      div_count   <= CNT_W'(DIV_W);
    end else if (cmd.mod_start) begin
      div_quot    <= {tick_next, {(DIV_W - 8){1'b0}}};
      div_divisor <= div_quot[7:0];
      div_rem     <= 8'd0;
      div_count   <= CNT_W'(8);
    end else if (cmd.div_step) begin
      div_quot  <= {div_quot[DIV_W-2:0], div_ge};
      div_rem   <= div_ge ? div_diff[7:0] : div_shifted[7:0];
      div_count <= div_count - CNT_W'(1);
    end
  end

  // Decide whether this tick steps the pattern
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.clear_hit) begin
      hit <= 1'b0;
    end else if (cmd.eval_period) begin
      hit <= !period_zero && period_big && (tick_next == 8'd0);
    end else if (cmd.eval_rem) begin
      hit <= (div_rem == 8'd0);
    end
  end

  // Commit pattern, counter and speed
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_pattern <= PATTERN_RESET;
      tick_count    <= 8'd0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        motor_speed[i] <= 8'd0;
      end
    end else if (cmd.commit && in_range) begin
      if (item_op == OP_LOAD) begin
        motor_speed[motor_idx] <= item_speed;
      end else begin
        tick_count             <= tick_next;
        motor_speed[motor_idx] <= speed_ramped;
        if (hit) begin
          phase_pattern <= pattern_rot;
        end
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      drive_phase <= nibble;
      stepped     <= is_tick && hit;
      if (!in_range) begin
        speed_now <= 8'd0;
      end else if (item_op == OP_LOAD) begin
        speed_now <= item_speed;
      end else begin
        speed_now <= speed_ramped;
      end
    end
  end

  `SPDR_ASSERT_SAME(a_mod_divisor_nonzero, cmd.mod_start, div_quot[7:0] != 8'd0)
  `SPDR_ASSERT_SAME(a_pattern_two_ones, 1'b1, $countones(phase_pattern) == 2)

endmodule

`default_nettype wire
